/* design/kpd_pkg.sv */
// kpd_pkg: shared types, codes and the key map of the 4x4 keypad scanner
// depends on nothing; used by the interfaces, the scan core, the register
// block and the top level
package kpd_pkg;

	localparam int unsigned ROW_W  = 4;
	localparam int unsigned COL_W  = 4;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned CNT_W  = 4;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [ROW_W-1:0]  ALL_ROWS  = 4'hF;
	localparam logic [CNT_W-1:0]  CNT_MAX   = 4'hF;
	localparam logic [CNT_W-1:0]  CONFIRM_RESET = 4'd1;
	localparam logic [CHAR_W-1:0] NO_KEY    = 7'd0;

	// register index, taken from paddr[2]
	localparam logic REG_CONFIRM = 1'b0;

	typedef enum logic [1:0] {
		PH_INIT,
		PH_WAIT,
		PH_SCAN,
		PH_RELEASE
	} phase_t;

	// one result item
	typedef struct packed {
		logic [ROW_W-1:0]  row_drive;
		logic              key_valid;
		logic [CHAR_W-1:0] key_char;
	} kpd_res_t;

	// ascii of the key at a row and column
	function automatic logic [CHAR_W-1:0] key_at(input logic [1:0] row,
			input logic [1:0] col);
		logic [7:0] ch;
		begin
			ch = 8'h00;
			unique case ({row, col})
				4'h0: ch = "3";
				4'h1: ch = "6";
				4'h2: ch = "9";
				4'h3: ch = "#";
				4'h4: ch = "1";
				4'h5: ch = "4";
				4'h6: ch = "7";
				4'h7: ch = "*";
				4'h8: ch = "2";
				4'h9: ch = "5";
				4'hA: ch = "8";
				4'hB: ch = "0";
				4'hC: ch = "A";
				4'hD: ch = "B";
				4'hE: ch = "C";
				4'hF: ch = "D";
				default: ch = 8'h00;
			endcase
			return ch[CHAR_W-1:0];
		end
	endfunction

endpackage

/* design/kpd_if.sv */
// kpd_col_if, kpd_res_if: valid/ready channels for column samples and results
// depends on kpd_pkg
interface kpd_col_if;
	import kpd_pkg::*;

	logic             valid;
	logic             ready;
	logic [COL_W-1:0] column_lines;

	modport source (output valid, output column_lines, input ready);
	modport sink (input valid, input column_lines, output ready);
endinterface

interface kpd_res_if;
	import kpd_pkg::*;

	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  row_drive;
	logic              key_valid;
	logic [CHAR_W-1:0] key_char;

	modport source (output valid, output row_drive, output key_valid, output key_char,
		input ready);
	modport sink (input valid, input row_drive, input key_valid, input key_char,
		output ready);
endinterface

/* design/matrix_keypad_scanner_unit.sv */
// matrix_keypad_scanner_unit: top level of the 4x4 keypad scanner
// depends on kpd_pkg, kpd_if, kpd_apb_regs and kpd_scan_core
//
//  channel   dir  handshake      payload
//  col_chan  in   valid/ready    column_lines[3:0]
//  key_chan  out  valid/ready    row_drive[3:0], key_valid, key_char[6:0]
//  apb       in   psel/penable   paddr[2:0], pwdata[31:0] -> prdata, pready
//
// one sample per cycle sustained while results are taken; a sample is registered in the
// input register on transfer and its result is then registered in the result register
// the scan state steps as the input register hands a sample to the result register
// a stalled result holds the result register; an empty input register still takes one
// more sample and then ready drops
// arst_n clears both valid flags, the scan state (init) and confirm_matches to one
module matrix_keypad_scanner_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	kpd_col_if.sink                      col_chan,
	kpd_res_if.source                    key_chan,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [kpd_pkg::PADDR_W-1:0]  paddr,
	input  logic [kpd_pkg::PDATA_W-1:0]  pwdata,
	output logic [kpd_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import kpd_pkg::*;

	logic [CNT_W-1:0] confirm;
	logic             vld_s1;
	logic [COL_W-1:0] cols_s1;
	logic             out_vld_q;
	kpd_res_t         res_q;
	kpd_res_t         res_n;
	logic             advance;

	kpd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.confirm (confirm)
	);

	kpd_scan_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.cols    (cols_s1),
		.confirm (confirm),
		.res     (res_n)
	);

	// handshake
	assign advance        = vld_s1 && (!out_vld_q || key_chan.ready);
	assign col_chan.ready = !vld_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (col_chan.ready) begin
			vld_s1 <= col_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (col_chan.valid && col_chan.ready) begin
			cols_s1 <= col_chan.column_lines;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (key_chan.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign key_chan.valid     = out_vld_q;
	assign key_chan.row_drive = res_q.row_drive;
	assign key_chan.key_valid = res_q.key_valid;
	assign key_chan.key_char  = res_q.key_char;

endmodule

/* design/kpd_apb_regs.sv */
// kpd_apb_regs: apb register block holding confirm_matches
// depends on kpd_pkg
module kpd_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [kpd_pkg::PADDR_W-1:0]  paddr,
	input  logic [kpd_pkg::PDATA_W-1:0]  pwdata,
	output logic [kpd_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [kpd_pkg::CNT_W-1:0]    confirm
);
	import kpd_pkg::*;

	logic [CNT_W-1:0] confirm_q;
	logic             sel_confirm;

	assign sel_confirm = (paddr[2] == REG_CONFIRM);
	assign pready      = 1'b1;
	assign confirm     = confirm_q;

	// write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_q <= CONFIRM_RESET;
		end else if (psel && penable && pwrite && sel_confirm) begin
			confirm_q <= pwdata[CNT_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (sel_confirm) begin
			prdata = {{(PDATA_W-CNT_W){1'b0}}, confirm_q};
		end
	end

endmodule

/* design/kpd_scan_core.sv */
// kpd_scan_core: scan state registers and the per-sample decision logic
// depends on kpd_pkg
module kpd_scan_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [kpd_pkg::COL_W-1:0] cols,
	input  logic [kpd_pkg::CNT_W-1:0] confirm,
	output kpd_pkg::kpd_res_t         res
);
	import kpd_pkg::*;

	phase_t            phase_q, phase_n;
	logic [1:0]        row_q, row_n;
	logic [CHAR_W-1:0] cand_q, cand_n;
	logic [CNT_W-1:0]  count_q, count_n;

	logic              hit;
	logic [1:0]        col_idx;
	logic [CHAR_W-1:0] key;
	logic [CNT_W-1:0]  count_inc;

	// one-hot column decode
	always_comb begin
		hit     = 1'b1;
		col_idx = 2'd0;
		unique case (cols)
			4'b0001: col_idx = 2'd0;
			4'b0010: col_idx = 2'd1;
			4'b0100: col_idx = 2'd2;
			4'b1000: col_idx = 2'd3;
			default: hit = 1'b0;
		endcase
	end

	assign key       = key_at(row_q, col_idx);
	assign count_inc = (count_q == CNT_MAX) ? CNT_MAX : count_q + 1'b1;

	// next state and result
	always_comb begin
		phase_n       = phase_q;
		row_n         = row_q;
		cand_n        = cand_q;
		count_n       = count_q;
		res.row_drive = ALL_ROWS;
		res.key_valid = 1'b0;
		res.key_char  = NO_KEY;
		unique case (phase_q)
			PH_WAIT: begin
				if (cols != '0) begin
					phase_n       = PH_SCAN;
					row_n         = 2'd0;
					cand_n        = NO_KEY;
					count_n       = '0;
					res.row_drive = 4'b0001;
				end
			end
			PH_SCAN: begin
				if (hit) begin
					if (cand_q == NO_KEY) begin
						cand_n = key;
					end else if (cand_q == key) begin
						count_n = count_inc;
						if (count_inc >= confirm) begin
							res.key_valid = 1'b1;
							res.key_char  = key;
							phase_n       = PH_RELEASE;
						end
					end else begin
						phase_n = PH_RELEASE;
					end
				end
				// still scanning: move on or give up after a keyless pass
				if (phase_n == PH_SCAN) begin
					if (row_q == 2'd3 && cand_n == NO_KEY) begin
						phase_n = PH_WAIT;
						row_n   = 2'd0;
					end else begin
						row_n         = row_q + 2'd1;
						res.row_drive = ROW_W'(1) << row_n;
					end
				end
			end
			PH_RELEASE: begin
				if (cols == '0) begin
					phase_n = PH_WAIT;
				end
			end
			PH_INIT: begin
				phase_n = PH_WAIT;
			end
			default: begin
				phase_n = PH_WAIT;
			end
		endcase
	end

	// state register, advanced once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INIT;
			row_q   <= 2'd0;
			cand_q  <= NO_KEY;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			row_q   <= row_n;
			cand_q  <= cand_n;
			count_q <= count_n;
		end
	end

endmodule

/* design/kpd_checker.sv */
// kpd_checker: port-level assertions for the keypad scanner, bound to the top
// depends on kpd_pkg
module kpd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [kpd_pkg::ROW_W-1:0]  row_drive,
	input logic                       key_valid,
	input logic [kpd_pkg::CHAR_W-1:0] key_char
);
	import kpd_pkg::*;

	// an emitted key always leaves all rows driven for the release wait
	a_emit_rows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_valid |-> row_drive == ALL_ROWS)
		else $error("key emitted without driving all rows");

	// character is present exactly when a key is emitted
	a_char_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (key_valid == (key_char != NO_KEY)))
		else $error("key_char disagrees with key_valid");

	// rows are either all driven or scanned one at a time
	a_row_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row_drive == ALL_ROWS || $onehot(row_drive)))
		else $error("illegal row drive pattern");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_drive)
			&& $stable(key_valid) && $stable(key_char))
		else $error("stalled result changed");

endmodule

bind matrix_keypad_scanner_unit kpd_checker u_kpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (key_chan.valid),
	.out_ready (key_chan.ready),
	.row_drive (key_chan.row_drive),
	.key_valid (key_chan.key_valid),
	.key_char  (key_chan.key_char)
);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for matrix_keypad_scanner_unit, a directed table of
// column samples, then keypad-like presses, releases and noise under idle and stall mixes
// depends on kpd_pkg, kpd_col_if, kpd_res_if and the scanner rtl
module tb_top;
	import kpd_pkg::*;

	// key characters, row r at index r, column 0 in the top byte
	localparam logic [3:0][31:0] KEY_ROWS = {"ABCD", "2580", "147*", "369#"};
	localparam int DIR_ROWS = 23;
	localparam logic [PADDR_W-1:0] CONFIRM_ADDR = {REG_CONFIRM, 2'b00};
	localparam kpd_res_t IDLE_RES = '{ALL_ROWS, 1'b0, NO_KEY};

	typedef struct packed {
		logic [COL_W-1:0] cols;
		logic             typed;
		kpd_res_t         res;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	kpd_col_if col_chan ();
	kpd_res_if key_chan ();

	matrix_keypad_scanner_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.col_chan (col_chan),
		.key_chan (key_chan),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// scanner state as the bench tracks it
	phase_t             scan_phase;
	logic [1:0]         scan_row;
	logic [ROW_W-1:0]   rows_out;
	logic [7:0]         cand_key;
	logic [CNT_W-1:0]   hit_count;
	logic [CNT_W-1:0]   confirm_setting;

	kpd_res_t expected_keys[$];
	int mismatches;
	int send_idle_pct;
	int stall_pct;
	int samples_sent;

	// simulated keypad: keys held down and chance of a corrupted sample
	int key_r[2];
	int key_c[2];
	int keys_held;
	int noise_pct;

	always #4 clk = ~clk;

	// next scanner state and the result of one column sample
	function automatic kpd_res_t scan_step(input logic [COL_W-1:0] cols);
		kpd_res_t res;
		logic [7:0] key;
		int col;
		res = IDLE_RES;
		case (cols)
			4'h1: col = 0;
			4'h2: col = 1;
			4'h4: col = 2;
			4'h8: col = 3;
			default: col = -1;
		endcase
		case (scan_phase)
			PH_WAIT: begin
				if (cols != '0) begin
					scan_phase = PH_SCAN;
					scan_row = 2'd0;
					cand_key = 8'h00;
					hit_count = '0;
					rows_out = 4'h1;
				end else begin
					rows_out = ALL_ROWS;
				end
			end
			PH_SCAN: begin
				// only a single active column decodes a key
				if (col >= 0) begin
					key = KEY_ROWS[scan_row][8*(3-col) +: 8];
					if (cand_key == 8'h00) begin
						cand_key = key;
					end else if (cand_key == key) begin
						if (hit_count < CNT_MAX)
							hit_count = hit_count + 1'b1;
						if (hit_count >= confirm_setting) begin
							res.key_valid = 1'b1;
							res.key_char = key[CHAR_W-1:0];
							scan_phase = PH_RELEASE;
							rows_out = ALL_ROWS;
						end
					end else begin
						// another key seen: give up without output
						scan_phase = PH_RELEASE;
						rows_out = ALL_ROWS;
					end
				end
				if (scan_phase == PH_SCAN) begin
					if (scan_row == 2'd3 && cand_key == 8'h00) begin
						scan_phase = PH_WAIT;
						scan_row = 2'd0;
						rows_out = ALL_ROWS;
					end else begin
						scan_row = scan_row + 2'd1;
						rows_out = 4'h1 << scan_row;
					end
				end
			end
			PH_RELEASE: begin
				rows_out = ALL_ROWS;
				if (cols == '0)
					scan_phase = PH_WAIT;
			end
			default: begin
				scan_phase = PH_WAIT;
				rows_out = ALL_ROWS;
			end
		endcase
		res.row_drive = rows_out;
		return res;
	endfunction

	// directed samples, run with confirm at its reset value of one
	function automatic dir_row_t directed_row(input int idx);
		case (idx)
			// init ignores the columns
			0:  return '{4'hF, 1'b1, IDLE_RES};
			1:  return '{4'h0, 1'b1, IDLE_RES};
			2:  return '{4'h1, 1'b1, '{4'h1, 1'b0, NO_KEY}};
			3:  return '{4'h0, 1'b0, IDLE_RES};
			// all columns at once is ignored
			4:  return '{4'hF, 1'b0, IDLE_RES};
			5:  return '{4'h0, 1'b0, IDLE_RES};
			// pass without a key goes back to waiting
			6:  return '{4'h0, 1'b1, IDLE_RES};
			7:  return '{4'h8, 1'b0, IDLE_RES};
			8:  return '{4'h8, 1'b0, IDLE_RES};
			9:  return '{4'h0, 1'b0, IDLE_RES};
			10: return '{4'h0, 1'b0, IDLE_RES};
			// unconfirmed candidate wraps back to row 0
			11: return '{4'h0, 1'b0, IDLE_RES};
			// second read of '#' confirms it
			12: return '{4'h8, 1'b1, '{ALL_ROWS, 1'b1, 7'h23}};
			13: return '{4'h8, 1'b1, IDLE_RES};
			14: return '{4'h0, 1'b1, IDLE_RES};
			15: return '{4'h4, 1'b0, IDLE_RES};
			16: return '{4'h0, 1'b0, IDLE_RES};
			17: return '{4'h0, 1'b0, IDLE_RES};
			18: return '{4'h0, 1'b0, IDLE_RES};
			// 'D' in the last row and column becomes the candidate
			19: return '{4'h8, 1'b0, IDLE_RES};
			20: return '{4'h0, 1'b0, IDLE_RES};
			// a different key aborts
			21: return '{4'h2, 1'b1, IDLE_RES};
			default: return '{4'h0, 1'b1, IDLE_RES};
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// one column sample transfer, taken from the table or from the simulated keypad
	task automatic drive_sample(input logic [COL_W-1:0] fixed_cols, input bit from_keys,
			input bit typed, input kpd_res_t typed_res);
		logic [COL_W-1:0] cols;
		kpd_res_t predicted;
		int k;
		while ($urandom_range(99) < send_idle_pct) begin
			col_chan.valid <= 1'b0;
			@(posedge clk);
		end
		cols = fixed_cols;
		if (from_keys) begin
			cols = '0;
			for (k = 0; k < keys_held; k++)
				if (rows_out[key_r[k]])
					cols[key_c[k]] = 1'b1;
			if ($urandom_range(99) < noise_pct)
				cols = cols ^ 4'($urandom_range(15));
		end
		col_chan.valid <= 1'b1;
		col_chan.column_lines <= cols;
		do @(posedge clk); while (!col_chan.ready);
		predicted = scan_step(cols);
		expected_keys.push_back(typed ? typed_res : predicted);
		samples_sent++;
	endtask

	// stop sending and let every outstanding result arrive
	task automatic drain();
		int guard;
		guard = 0;
		col_chan.valid <= 1'b0;
		while (expected_keys.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic check_confirm();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CONFIRM_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CNT_W-1:0] !== confirm_setting)
			flag_mismatch($sformatf("confirm_matches read %0h, expected %0h",
				prdata[CNT_W-1:0], confirm_setting));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_confirm(input logic [CNT_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		word[CNT_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CONFIRM_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		confirm_setting = value;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		check_confirm();
	endtask

	// random key presses, multi-key presses and noise at one setting
	task automatic run_phase(input int send_pct, input int stall, input logic [CNT_W-1:0] value,
			input int n);
		int target;
		int pick;
		int len;
		bit paused;
		stall_pct = stall;
		send_idle_pct = send_pct;
		drain();
		set_confirm(value);
		target = samples_sent + n;
		paused = 1'b0;
		while (samples_sent < target) begin
			// hold off once until everything sent has come back
			if (!paused && samples_sent >= target - n / 2) begin
				drain();
				paused = 1'b1;
			end
			pick = $urandom_range(99);
			keys_held = (pick < 70) ? 1 : ((pick < 85) ? 2 : 0);
			key_r[0] = $urandom_range(3);
			key_c[0] = $urandom_range(3);
			key_r[1] = $urandom_range(3);
			key_c[1] = $urandom_range(3);
			noise_pct = ($urandom_range(3) == 0) ? 10 : 0;
			if (keys_held == 0) begin
				noise_pct = 100;
				len = $urandom_range(1, 8);
			end else if ($urandom_range(3) == 0) begin
				len = $urandom_range(1, 12);
			end else begin
				len = 4 * (int'(confirm_setting) + 2) + $urandom_range(0, 8);
			end
			repeat (len) drive_sample('0, 1'b1, 1'b0, IDLE_RES);
			// key released
			keys_held = 0;
			noise_pct = 0;
			repeat ($urandom_range(1, 5)) drive_sample('0, 1'b1, 1'b0, IDLE_RES);
		end
	endtask

	// result check, then a new ready for the next cycle
	always @(posedge clk) begin
		kpd_res_t want;
		if (key_chan.valid && key_chan.ready) begin
			if (expected_keys.size() == 0) begin
				flag_mismatch("result transfer with nothing expected");
			end else begin
				want = expected_keys.pop_front();
				if (key_chan.row_drive !== want.row_drive)
					flag_mismatch($sformatf("row_drive %0h, expected %0h",
						key_chan.row_drive, want.row_drive));
				if (key_chan.key_valid !== want.key_valid)
					flag_mismatch($sformatf("key_valid %0b, expected %0b",
						key_chan.key_valid, want.key_valid));
				if (key_chan.key_char !== want.key_char)
					flag_mismatch($sformatf("key_char %0h, expected %0h",
						key_chan.key_char, want.key_char));
			end
		end
		key_chan.ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#5000000;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		int i;
		dir_row_t row;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		col_chan.valid = 1'b0;
		col_chan.column_lines = '0;
		key_chan.ready = 1'b0;
		scan_phase = PH_INIT;
		scan_row = 2'd0;
		rows_out = '0;
		cand_key = 8'h00;
		hit_count = '0;
		confirm_setting = CONFIRM_RESET;
		mismatches = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		samples_sent = 0;
		keys_held = 0;
		noise_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_confirm();

		for (i = 0; i < DIR_ROWS; i++) begin
			row = directed_row(i);
			drive_sample(row.cols, 1'b0, row.typed, row.res);
		end

		run_phase(0, 0, 4'd15, 190);
		run_phase(79, 0, 4'd0, 190);
		run_phase(0, 79, 4'($urandom_range(2, 14)), 190);
		run_phase(7, 7, 4'd1, 190);
		run_phase(0, 0, 4'($urandom_range(1, 15)), 190);

		drain();
		if (expected_keys.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_keys.size()));
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
